@@ rtl/vpfa_pkg.sv @@
// Shared types and constants for the video payload frame assembler.
// No dependencies; used by every module of the block.
`default_nettype none
package vpfa_pkg;

  localparam int unsigned BUFFER_BYTES = 1048576;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PLEN_W   = 12;
  localparam int unsigned CAP_W    = 21;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 56;

  localparam logic [BYTE_W-1:0] HDR_MIN   = 8'd2;
  localparam logic [PLEN_W-1:0] PLEN_MIN  = 12'd2;
  localparam int unsigned       FLAG_ERR  = 6;
  localparam int unsigned       FLAG_EOF  = 1;
  localparam logic [CAP_W-1:0]  CAP_RESET = 21'd1048576;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [BYTE_W-1:0] byte_value;
    logic [PLEN_W-1:0] packet_length;
    logic              packet_error;
    logic              last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    logic              frame_done;
    logic [CAP_W-1:0]  frame_length;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/vpfa_in_reg.sv @@
// Input register stage of the frame assembler.
// Depends on vpfa_pkg for the input item type.
`default_nettype none
module vpfa_in_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire vpfa_pkg::in_item_t  item_i,
  output logic                     valid_o,
  output vpfa_pkg::in_item_t       item_o,
  input  wire logic                advance_i
);

  logic               valid_q;
  vpfa_pkg::in_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vpfa_core.sv @@
// Packet parsing state and the per-item frame assembly step.
// Depends on vpfa_pkg for item, result types and header constants.
`default_nettype none
module vpfa_core #(
  parameter int unsigned PACKET_BYTES_MAX = 3072
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire vpfa_pkg::in_item_t            item_i,
  input  wire logic [vpfa_pkg::CAP_W-1:0]    cap_i,
  output vpfa_pkg::result_t                  result_o
);

  localparam int unsigned PW = $clog2(PACKET_BYTES_MAX + 1);
  localparam int unsigned CW = (PW > vpfa_pkg::PLEN_W) ? PW : vpfa_pkg::PLEN_W;
  localparam logic [PW-1:0] POS_MAX = PW'(PACKET_BYTES_MAX);

  logic                          done_q, done_d;
  logic [vpfa_pkg::CAP_W-1:0]    bytes_q, bytes_d;
  logic [PW-1:0]                 pos_q, pos_d;
  logic [vpfa_pkg::BYTE_W-1:0]   hdr_q, hdr_d;
  logic                          ign_q, ign_d;
  logic                          eof_q, eof_d;
  logic                          ovf_q, ovf_d;

  logic          pos0, pos1, in_range, store_cand, has_room, wv;
  logic [CW-1:0] pos_x, plen_x, hdr_x;

  always_comb begin
    pos_x  = CW'(pos_q);
    plen_x = CW'(item_i.packet_length);
    pos0   = (pos_q == '0);
    pos1   = (pos_q == PW'(1));
    in_range = (pos_q < POS_MAX) && (pos_x < plen_x);

    done_d   = done_q;
    bytes_d  = bytes_q;
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    ign_d    = ign_q;
    eof_d    = eof_q;
    ovf_d    = ovf_q;
    hdr_x    = '0;
    store_cand = 1'b0;
    has_room = 1'b0;
    wv       = 1'b0;

    if (item_i.operation == vpfa_pkg::OP_START) begin
      done_d  = 1'b0;
      bytes_d = '0;
      pos_d   = '0;
      hdr_d   = '0;
      ign_d   = 1'b0;
      eof_d   = 1'b0;
      ovf_d   = 1'b0;
    end else begin
      if (pos0) begin
        hdr_d = item_i.byte_value;
        eof_d = 1'b0;
        ovf_d = 1'b0;
        ign_d = done_q || item_i.packet_error
             || (item_i.packet_length < vpfa_pkg::PLEN_MIN)
             || (item_i.byte_value < vpfa_pkg::HDR_MIN)
             || (vpfa_pkg::PLEN_W'(item_i.byte_value) > item_i.packet_length);
      end else if (pos1) begin
        if (item_i.byte_value[vpfa_pkg::FLAG_ERR]) begin
          ign_d = 1'b1;
        end
        eof_d = item_i.byte_value[vpfa_pkg::FLAG_EOF];
      end

      hdr_x      = CW'(hdr_d);
      store_cand = !ign_d && in_range && (pos_x >= hdr_x);
      has_room   = (bytes_q < cap_i);
      wv         = store_cand && has_room;
      if (wv) begin
        bytes_d = bytes_q + vpfa_pkg::CAP_W'(1);
      end
      if (store_cand && !has_room) begin
        ovf_d = 1'b1;
      end

      if (item_i.last_of_packet) begin
        if (!ign_d && (ovf_d || (eof_d && (bytes_d != '0)))) begin
          done_d = 1'b1;
        end
        pos_d = '0;
      end else if (pos_q < POS_MAX) begin
        pos_d = pos_q + PW'(1);
      end
    end

    result_o.write_valid   = wv;
    result_o.write_address = wv ? bytes_q[vpfa_pkg::ADDR_W-1:0] : '0;
    result_o.write_data    = wv ? item_i.byte_value : '0;
    result_o.frame_done    = done_d;
    result_o.frame_length  = bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      bytes_q <= '0;
      pos_q   <= '0;
      hdr_q   <= '0;
      ign_q   <= 1'b0;
      eof_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (fire_i) begin
      done_q  <= done_d;
      bytes_q <= bytes_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      ign_q   <= ign_d;
      eof_q   <= eof_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vpfa_out_reg.sv @@
// Result register stage of the frame assembler.
// Depends on vpfa_pkg for the result type.
`default_nettype none
module vpfa_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire vpfa_pkg::result_t  result_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output vpfa_pkg::result_t       result_o
);

  logic              valid_q;
  vpfa_pkg::result_t result_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/video_payload_frame_assembler_top.sv @@
// Video payload frame assembler: one packet byte per item in, one frame buffer
// write result per item out. Throughput is one item per clock while m_axis_tready
// does not stall the result register; each accepted item passes the input register,
// the combinational parsing step and the result register on its way to the output.
// The capacity register is written through the cfg channel, which is always ready.
// Depends on vpfa_pkg, vpfa_in_reg, vpfa_core and vpfa_out_reg.
`default_nettype none
module video_payload_frame_assembler_top #(
  parameter int unsigned PACKET_BYTES_MAX = 3072
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [vpfa_pkg::CAP_W-1:0]        cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // byte_value[7:0], packet_length[19:8], packet_error[20], zero[23:21]
  input  wire logic [vpfa_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // operation[0]
  input  wire logic                              s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // write_address[19:0], write_data[27:20], frame_done[28],
  // frame_length[49:29], zero[55:50]
  output logic [vpfa_pkg::M_DATA_W-1:0]          m_axis_tdata,
  // write_valid[0]
  output logic                                   m_axis_tuser
);

  logic [vpfa_pkg::CAP_W-1:0] cap_q, cap_d;
  vpfa_pkg::in_item_t s_item, core_item;
  vpfa_pkg::result_t  core_result, m_result;
  logic core_valid, out_ready, fire;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (32'(cfg_data_i) > vpfa_pkg::BUFFER_BYTES) begin
      cap_d = vpfa_pkg::CAP_W'(vpfa_pkg::BUFFER_BYTES);
    end else begin
      cap_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= (32'(vpfa_pkg::CAP_RESET) > vpfa_pkg::BUFFER_BYTES)
             ? vpfa_pkg::CAP_W'(vpfa_pkg::BUFFER_BYTES) : vpfa_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cap_d;
    end
  end

  always_comb begin
    s_item.operation      = vpfa_pkg::op_e'(s_axis_tuser);
    s_item.byte_value     = s_axis_tdata[7:0];
    s_item.packet_length  = s_axis_tdata[19:8];
    s_item.packet_error   = s_axis_tdata[20];
    s_item.last_of_packet = s_axis_tlast;
  end

  vpfa_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (s_item),
    .valid_o   (core_valid),
    .item_o    (core_item),
    .advance_i (fire)
  );

  assign fire = core_valid && out_ready;

  vpfa_core #(
    .PACKET_BYTES_MAX (PACKET_BYTES_MAX)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (core_item),
    .cap_i    (cap_q),
    .result_o (core_result)
  );

  vpfa_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (core_valid),
    .ready_o  (out_ready),
    .result_i (core_result),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (m_result)
  );

  assign m_axis_tuser = m_result.write_valid;
  assign m_axis_tdata = {6'd0, m_result.frame_length, m_result.frame_done,
                         m_result.write_data, m_result.write_address};

endmodule
`default_nettype wire
